FILE: rtl/sample_consensus_background_subtractor_macros.svh
// assertion macros for the background subtractor
`ifndef SAMPLE_CONSENSUS_BACKGROUND_SUBTRACTOR_MACROS_SVH
`define SAMPLE_CONSENSUS_BACKGROUND_SUBTRACTOR_MACROS_SVH

// same-cycle implication on clk, off during reset
`define SCBS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scbs assertion failed");

// next-cycle implication on clk, off during reset
`define SCBS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scbs assertion failed");

`endif

FILE: rtl/scbs_pkg.sv
// package: types, constants and helpers of the background subtractor
`timescale 1ns / 1ps
package scbs_pkg;
	localparam int SAMPLES = 20;
	localparam int SLOT_W = 5;
	localparam int ROW_W = 7;
	localparam int COL_W = 7;
	localparam int PIDX_W = ROW_W + COL_W;
	localparam int PIXELS = 2 ** PIDX_W;
	localparam int MATCH_W = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;
	localparam logic [7:0] MAX_ROWS = 8'd128;
	localparam logic [7:0] MAX_COLS = 8'd128;
	localparam logic [7:0] COUNT_MAX = 8'd255;

	localparam logic [CFG_IDX_W-1:0] REG_BG_QUORUM = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERSIST_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 3'd4;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_CLASSIFY = 1'b1;

	localparam logic signed [1:0] OFFSETS [9] = '{
		-2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd0
	};

	typedef struct packed {
		logic       command;
		logic [6:0] row;
		logic [6:0] col;
		logic [7:0] pixel;
		logic [4:0] sample_pick;
		logic [4:0] neighbour_sample_pick;
		logic [3:0] self_draw;
		logic [3:0] neighbour_draw;
		logic [3:0] dy_pick;
		logic [3:0] dx_pick;
		logic [3:0] absorb_draw;
	} in_word_t;

	typedef struct packed {
		logic       foreground;
		logic [7:0] persist_count;
	} out_word_t;

	typedef struct packed {
		logic [4:0] bg_quorum;
		logic [7:0] radius;
		logic [7:0] persist_limit;
		logic [7:0] rows_in_use;
		logic [7:0] cols_in_use;
	} cfg_t;

	typedef struct packed {
		logic              command;
		logic [PIDX_W-1:0] pidx;
		logic [PIDX_W-1:0] nidx;
		logic [7:0]        pixel;
		logic [SLOT_W-1:0] slot;
		logic [SLOT_W-1:0] nslot;
		logic              self_en;
		logic              nbr_en;
		logic              absorb_en;
	} job_t;

	typedef struct packed {
		logic clearing;
		logic idle;
	} back_stat_t;

	function automatic logic signed [1:0] pick_offset(logic [3:0] pick);
		logic signed [1:0] off;
		off = 2'sd0;
		if (pick <= 4'd8) begin
			off = OFFSETS[pick];
		end
		return off;
	endfunction
endpackage

FILE: rtl/scbs_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module scbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

FILE: rtl/scbs_front.sv
// front end: clamps coordinates, reduces picks and decodes draws into a job
`timescale 1ns / 1ps
module scbs_front (
	input  scbs_pkg::in_word_t in_word,
	input  scbs_pkg::cfg_t     cfg,
	output scbs_pkg::job_t     job
);
	logic [7:0] rows_eff, cols_eff;
	logic [6:0] r, c, nr, nc;
	logic signed [1:0] dy, dx;

	function automatic logic [6:0] move(logic [6:0] v, logic signed [1:0] off,
			logic [7:0] size);
		logic [6:0] res;
		res = v;
		if (off < 0) begin
			res = (v == 7'd0) ? 7'd0 : v - 7'd1;
		end else if (off > 0) begin
			res = (({1'b0, v} + 8'd1) >= size) ? 7'(size - 8'd1) : v + 7'd1;
		end
		return res;
	endfunction

	function automatic logic [4:0] slot_mod(logic [4:0] p);
		return (p >= 5'(scbs_pkg::SAMPLES)) ? p - 5'(scbs_pkg::SAMPLES) : p;
	endfunction

	always_comb begin
		rows_eff = (cfg.rows_in_use == 8'd0) ? 8'd1 :
			(cfg.rows_in_use > scbs_pkg::MAX_ROWS) ? scbs_pkg::MAX_ROWS : cfg.rows_in_use;
		cols_eff = (cfg.cols_in_use == 8'd0) ? 8'd1 :
			(cfg.cols_in_use > scbs_pkg::MAX_COLS) ? scbs_pkg::MAX_COLS : cfg.cols_in_use;
		r = ({1'b0, in_word.row} >= rows_eff) ? 7'(rows_eff - 8'd1) : in_word.row;
		c = ({1'b0, in_word.col} >= cols_eff) ? 7'(cols_eff - 8'd1) : in_word.col;
		dy = scbs_pkg::pick_offset(in_word.dy_pick);
		dx = scbs_pkg::pick_offset(in_word.dx_pick);
		nr = move(r, dy, rows_eff);
		nc = move(c, dx, cols_eff);
		job.command = in_word.command;
		job.pidx = {r, c};
		job.nidx = {nr, nc};
		job.pixel = in_word.pixel;
		job.slot = slot_mod(in_word.sample_pick);
		job.nslot = slot_mod(in_word.neighbour_sample_pick);
		job.self_en = (in_word.self_draw == 4'd0);
		job.nbr_en = (in_word.neighbour_draw == 4'd0);
		job.absorb_en = (in_word.absorb_draw == 4'd0);
	end
endmodule

FILE: rtl/scbs_queue.sv
// two-entry job queue between front and back
`timescale 1ns / 1ps
module scbs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  scbs_pkg::job_t push_job,
	input  logic           pop,
	output scbs_pkg::job_t head,
	output logic           full,
	output logic           empty
);
	scbs_pkg::job_t mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign head = mem_q[rd_q];
	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

FILE: rtl/scbs_back.sv
// back end: sample and count memories, match count, updates, result register
`timescale 1ns / 1ps
module scbs_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  scbs_pkg::cfg_t        cfg,
	input  scbs_pkg::job_t        head,
	input  logic                  empty,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output scbs_pkg::out_word_t   out_word,
	output scbs_pkg::back_stat_t  stat
);
	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_EVAL  = 4'b0100,
		ST_NBR   = 4'b1000
	} state_t;

	state_t state_q;
	scbs_pkg::job_t job_q;
	logic [scbs_pkg::PIDX_W-1:0] clr_q;
	logic out_valid_q;
	scbs_pkg::out_word_t out_word_q;

	logic [scbs_pkg::PIDX_W-1:0] lane_addr, cnt_addr;
	logic [7:0] lane_rdata [scbs_pkg::SAMPLES];
	logic [scbs_pkg::SAMPLES-1:0] lane_we, close;
	logic [7:0] old_cnt, inc_cnt, cnt_wdata;
	logic cnt_we;
	logic [scbs_pkg::MATCH_W-1:0] match_cnt;
	logic bg, own_we, nbr_go;
	logic [7:0] diff;

	assign pop = (state_q == ST_IDLE) && !empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_word = out_word_q;
	assign stat.clearing = (state_q == ST_CLEAR);
	assign stat.idle = (state_q == ST_IDLE);

	always_comb begin
		close = '0;
		diff = 8'd0;
		for (int i = 0; i < scbs_pkg::SAMPLES; i++) begin
			diff = (lane_rdata[i] > job_q.pixel) ? lane_rdata[i] - job_q.pixel :
				job_q.pixel - lane_rdata[i];
			close[i] = (diff < cfg.radius);
		end
		match_cnt = scbs_pkg::MATCH_W'($countones(close));
		bg = (match_cnt >= cfg.bg_quorum);
		inc_cnt = (old_cnt == scbs_pkg::COUNT_MAX) ? old_cnt : old_cnt + 8'd1;
		if (job_q.command == scbs_pkg::CMD_LOAD) begin
			own_we = 1'b1;
		end else if (bg) begin
			own_we = job_q.self_en;
		end else begin
			own_we = (inc_cnt > cfg.persist_limit) && job_q.absorb_en;
		end
		nbr_go = (job_q.command == scbs_pkg::CMD_CLASSIFY) && bg && job_q.nbr_en;
		for (int i = 0; i < scbs_pkg::SAMPLES; i++) begin
			lane_we[i] = ((state_q == ST_EVAL) && own_we &&
				(job_q.slot == scbs_pkg::SLOT_W'(i))) ||
				((state_q == ST_NBR) && (job_q.nslot == scbs_pkg::SLOT_W'(i)));
		end
		lane_addr = (state_q == ST_NBR) ? job_q.nidx :
			(state_q == ST_EVAL) ? job_q.pidx : head.pidx;
		cnt_addr = (state_q == ST_CLEAR) ? clr_q :
			(state_q == ST_EVAL) ? job_q.pidx : head.pidx;
		cnt_we = (state_q == ST_CLEAR) ||
			((state_q == ST_EVAL) && (job_q.command == scbs_pkg::CMD_CLASSIFY));
		cnt_wdata = ((state_q == ST_CLEAR) || bg) ? 8'd0 : inc_cnt;
	end

	for (genvar g = 0; g < scbs_pkg::SAMPLES; g++) begin : g_lane
		scbs_ram #(.WIDTH(8), .DEPTH(scbs_pkg::PIXELS)) u_lane (
			.clk   (clk),
			.we    (lane_we[g]),
			.addr  (lane_addr),
			.wdata (job_q.pixel),
			.rdata (lane_rdata[g])
		);
	end

	scbs_ram #(.WIDTH(8), .DEPTH(scbs_pkg::PIXELS)) u_count (
		.clk   (clk),
		.we    (cnt_we),
		.addr  (cnt_addr),
		.wdata (cnt_wdata),
		.rdata (old_cnt)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (state_q == ST_EVAL) begin
			if (job_q.command == scbs_pkg::CMD_LOAD) begin
				out_word_q <= '{foreground: 1'b0, persist_count: old_cnt};
			end else if (bg) begin
				out_word_q <= '{foreground: 1'b0, persist_count: 8'd0};
			end else begin
				out_word_q <= '{foreground: 1'b1, persist_count: inc_cnt};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EVAL) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + scbs_pkg::PIDX_W'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= nbr_go ? ST_NBR : ST_IDLE;
				end
				ST_NBR: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

FILE: rtl/sample_consensus_background_subtractor.sv
// top level: config registers, front end, job queue and back end
//
// channel   direction  handshake          payload
// in        input      in_valid/in_stall  in_word  (scbs_pkg::in_word_t)
// out       output     out_valid/out_stall out_word (scbs_pkg::out_word_t)
// cfg       input      cfg_we             cfg_index, cfg_data
//
// a word is read in idle, then evaluated and written in eval; a neighbour
// sample is written in nbr, set by the single port of each sample lane ram
// after reset all 16384 count ram entries are cleared; in_stall is high then
// the front is combinational; a two-entry queue decouples it from the back end
// the back end holds a word while its result register waits on out_stall
`timescale 1ns / 1ps
`include "sample_consensus_background_subtractor_macros.svh"
module sample_consensus_background_subtractor (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  scbs_pkg::in_word_t                    in_word,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output scbs_pkg::out_word_t                   out_word,
	input  logic                                  cfg_we,
	input  logic [scbs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [scbs_pkg::CFG_DATA_W-1:0]       cfg_data
);
	scbs_pkg::cfg_t cfg_q;
	scbs_pkg::job_t front_job, head;
	scbs_pkg::back_stat_t stat;
	logic full, empty, pop, push;

	assign in_stall = full || stat.clearing;
	assign push = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{bg_quorum: 5'd2, radius: 8'd20, persist_limit: 8'd25,
				rows_in_use: 8'd128, cols_in_use: 8'd128};
		end else if (cfg_we) begin
			unique case (cfg_index)
				scbs_pkg::REG_BG_QUORUM:     cfg_q.bg_quorum <= cfg_data[4:0];
				scbs_pkg::REG_RADIUS:        cfg_q.radius <= cfg_data;
				scbs_pkg::REG_PERSIST_LIMIT: cfg_q.persist_limit <= cfg_data;
				scbs_pkg::REG_ROWS_IN_USE:   cfg_q.rows_in_use <= cfg_data;
				scbs_pkg::REG_COLS_IN_USE:   cfg_q.cols_in_use <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	scbs_front u_front (
		.in_word (in_word),
		.cfg     (cfg_q),
		.job     (front_job)
	);

	scbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (front_job),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	scbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.stat      (stat)
	);

	`SCBS_ASSERT_NOW(a_pop_nonempty, pop, !empty && stat.idle)
	`SCBS_ASSERT_NOW(a_no_result_while_clearing, stat.clearing, !out_valid)
	`SCBS_ASSERT_NEXT(a_queue_empty_after_clear, stat.clearing, !stat.clearing || empty)
endmodule
